// ===== hdl/stl_pkg.sv =====
// shared types, codes and character class functions for the source token lexer
`default_nettype none

package stl_pkg;

    localparam int BYTE_W  = 8;
    localparam int CLASS_W = 4;
    localparam int MODE_W  = 4;

    // scan modes
    localparam logic [MODE_W-1:0] MODE_IDLE   = 4'd0;
    localparam logic [MODE_W-1:0] MODE_ALNUM  = 4'd1;
    localparam logic [MODE_W-1:0] MODE_PUNCT  = 4'd2;
    localparam logic [MODE_W-1:0] MODE_PAIR2  = 4'd3;
    localparam logic [MODE_W-1:0] MODE_STRING = 4'd4;
    localparam logic [MODE_W-1:0] MODE_LINE   = 4'd5;
    localparam logic [MODE_W-1:0] MODE_BOPEN  = 4'd6;
    localparam logic [MODE_W-1:0] MODE_BLOCK  = 4'd7;
    localparam logic [MODE_W-1:0] MODE_BEND   = 4'd8;

    // token classes
    localparam logic [CLASS_W-1:0] CLS_ALNUM   = 4'd0;
    localparam logic [CLASS_W-1:0] CLS_PUNCT   = 4'd1;
    localparam logic [CLASS_W-1:0] CLS_SINGLE  = 4'd2;
    localparam logic [CLASS_W-1:0] CLS_PAIR    = 4'd3;
    localparam logic [CLASS_W-1:0] CLS_STRING  = 4'd4;
    localparam logic [CLASS_W-1:0] CLS_LINE    = 4'd5;
    localparam logic [CLASS_W-1:0] CLS_BLOCK   = 4'd6;
    localparam logic [CLASS_W-1:0] CLS_NEWLINE = 4'd7;
    localparam logic [CLASS_W-1:0] CLS_INVALID = 4'd8;

    // characters with a role of their own
    localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'd34;
    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'd36;
    localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_NL     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_EQ     = 8'h3D;
    localparam logic [BYTE_W-1:0] CH_LT     = 8'h3C;
    localparam logic [BYTE_W-1:0] CH_GT     = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_LBRK   = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_RBRK   = 8'h5D;
    localparam logic [BYTE_W-1:0] CH_LPAR   = 8'h28;
    localparam logic [BYTE_W-1:0] CH_RPAR   = 8'h29;
    localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;
    localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;

    typedef struct packed {
        logic               emit;
        logic [CLASS_W-1:0] cls;
        logic               last;
        logic [MODE_W-1:0]  next_mode;
    } decision_t;

    function automatic logic is_blank(input logic [BYTE_W-1:0] c);
        return ((c >= 8'd9) && (c <= 8'd13) && (c != CH_NL)) || (c == CH_SPACE);
    endfunction

    function automatic logic is_alnum(input logic [BYTE_W-1:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h5A))
            || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_punct(input logic [BYTE_W-1:0] c);
        return (c >= 8'd33) && (c <= 8'd126) && !is_alnum(c);
    endfunction

    function automatic logic is_quote(input logic [BYTE_W-1:0] c);
        return (c == CH_DQUOTE) || (c == CH_DOLLAR);
    endfunction

    function automatic logic is_special(input logic [BYTE_W-1:0] c);
        return (c == CH_LT) || (c == CH_GT) || (c == CH_LBRK) || (c == CH_RBRK)
            || (c == CH_COLON) || (c == CH_LPAR) || (c == CH_RPAR) || (c == CH_LBRACE)
            || (c == CH_RBRACE) || (c == CH_EQ) || (c == CH_PLUS) || (c == CH_MINUS)
            || (c == CH_STAR) || (c == CH_SLASH);
    endfunction

    function automatic logic is_pair(input logic [BYTE_W-1:0] h,
                                     input logic [BYTE_W-1:0] n);
        logic res;
        if (n == CH_EQ)
        begin
            res = (h == CH_EQ) || (h == CH_PLUS) || (h == CH_MINUS)
               || (h == CH_STAR) || (h == CH_SLASH);
        end
        else
        begin
            res = (n == h) && ((h == CH_LT) || (h == CH_GT) || (h == CH_COLON)
               || (h == CH_PLUS) || (h == CH_MINUS));
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/source_token_lexer_core.sv =====
// top level of the source token lexer: lookahead register, decision and result register
//
//  channel  dir  tdata                  tuser                        tlast
//  s_*      in   stream_byte[7:0]       end_of_stream[0]             -
//  m_*      out  token_byte[7:0]        token_class[3:0],first[4]    last_of_token
//
// one word accepted per cycle while s_tready is high; a result appears in the cycle
// after the word completing its lookahead, so each output trails the input by one word
// the held byte, its first mark and the scan mode sit in registers between words
// reset clears the scan mode, the held flag and the result valid
// s_tready stays high while the result register is empty or being drained
`default_nettype none

module source_token_lexer_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [stl_pkg::BYTE_W-1:0]  s_tdata,   // stream_byte
    input  wire logic                        s_tuser,   // end_of_stream
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [stl_pkg::BYTE_W-1:0]       m_tdata,   // token_byte
    output logic [stl_pkg::CLASS_W:0]        m_tuser,   // token_class, first_of_token
    output logic                             m_tlast    // last_of_token
);
    import stl_pkg::*;

    logic [MODE_W-1:0]  mode_reg;
    logic [MODE_W-1:0]  mode_next;
    logic [BYTE_W-1:0]  held_reg;
    logic               held_valid_reg;
    logic               held_first_reg;
    logic               out_valid_reg;
    logic [BYTE_W-1:0]  out_byte_reg;
    logic [CLASS_W-1:0] out_cls_reg;
    logic               out_first_reg;
    logic               out_last_reg;
    logic               accept;
    logic               produce;
    decision_t          dec;

    stl_decide u_decide (
        .mode  (mode_reg),
        .held  (held_reg),
        .ahead (s_tdata),
        .eos   (s_tuser),
        .dec   (dec)
    );

    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign produce   = accept && held_valid_reg && dec.emit;
    assign mode_next = held_valid_reg ? dec.next_mode : mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            held_valid_reg <= 1'b0;
            held_first_reg <= 1'b0;
            held_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                if (s_tuser)
                begin
                    mode_reg       <= MODE_IDLE;
                    held_valid_reg <= 1'b0;
                    held_first_reg <= 1'b0;
                    held_reg       <= '0;
                end
                else
                begin
                    mode_reg       <= mode_next;
                    held_valid_reg <= 1'b1;
                    held_first_reg <= (mode_next == MODE_IDLE);
                    held_reg       <= s_tdata;
                end
            end
            if (produce)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (produce)
        begin
            out_byte_reg  <= held_reg;
            out_cls_reg   <= dec.cls;
            out_first_reg <= held_first_reg;
            out_last_reg  <= dec.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = {out_first_reg, out_cls_reg};
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== hdl/stl_decide.sv =====
// decides the held byte against its lookahead: emit, class, end mark and next scan mode
`default_nettype none

module stl_decide (
    input  wire logic [stl_pkg::MODE_W-1:0] mode,
    input  wire logic [stl_pkg::BYTE_W-1:0] held,
    input  wire logic [stl_pkg::BYTE_W-1:0] ahead,
    input  wire logic                       eos,
    output stl_pkg::decision_t              dec
);
    import stl_pkg::*;

    logic              la_alnum;
    logic              la_punct;
    logic              la_nl;
    logic              la_slash;
    logic              la_star;
    logic              la_pair;
    logic [MODE_W-1:0] nm;

    assign la_alnum = !eos && is_alnum(ahead);
    assign la_punct = !eos && is_punct(ahead);
    assign la_nl    = !eos && (ahead == CH_NL);
    assign la_slash = !eos && (ahead == CH_SLASH);
    assign la_star  = !eos && (ahead == CH_STAR);
    assign la_pair  = !eos && is_pair(held, ahead);

    always_comb
    begin
        dec.emit = 1'b1;
        dec.cls  = CLS_ALNUM;
        dec.last = 1'b0;
        nm       = MODE_IDLE;
        unique case (mode)
            MODE_ALNUM:
            begin
                dec.cls  = CLS_ALNUM;
                dec.last = !la_alnum;
                nm       = la_alnum ? MODE_ALNUM : MODE_IDLE;
            end
            MODE_PUNCT:
            begin
                dec.cls  = CLS_PUNCT;
                dec.last = !la_punct;
                nm       = la_punct ? MODE_PUNCT : MODE_IDLE;
            end
            MODE_PAIR2:
            begin
                dec.cls  = CLS_PAIR;
                dec.last = 1'b1;
            end
            MODE_STRING:
            begin
                dec.cls  = CLS_STRING;
                dec.last = is_quote(held) || eos;
                nm       = dec.last ? MODE_IDLE : MODE_STRING;
            end
            MODE_LINE:
            begin
                dec.cls  = CLS_LINE;
                dec.last = la_nl || eos;
                nm       = dec.last ? MODE_IDLE : MODE_LINE;
            end
            MODE_BOPEN:
            begin
                dec.cls  = CLS_BLOCK;
                dec.last = eos;
                nm       = MODE_BLOCK;
            end
            MODE_BLOCK:
            begin
                dec.cls = CLS_BLOCK;
                if ((held == CH_STAR) && la_slash)
                begin
                    nm = MODE_BEND;
                end
                else
                begin
                    dec.last = eos;
                    nm       = MODE_BLOCK;
                end
            end
            MODE_BEND:
            begin
                dec.cls  = CLS_BLOCK;
                dec.last = 1'b1;
            end
            default:
            begin
                if (is_blank(held))
                begin
                    dec.emit = 1'b0;
                end
                else if ((held == CH_SLASH) && la_slash)
                begin
                    dec.cls = CLS_LINE;
                    nm      = MODE_LINE;
                end
                else if ((held == CH_SLASH) && la_star)
                begin
                    dec.cls = CLS_BLOCK;
                    nm      = MODE_BOPEN;
                end
                else if (held == CH_NL)
                begin
                    dec.cls  = CLS_NEWLINE;
                    dec.last = 1'b1;
                end
                else if (is_alnum(held))
                begin
                    dec.cls  = CLS_ALNUM;
                    dec.last = !la_alnum;
                    nm       = la_alnum ? MODE_ALNUM : MODE_IDLE;
                end
                else if (is_quote(held))
                begin
                    dec.cls  = CLS_STRING;
                    dec.last = eos;
                    nm       = MODE_STRING;
                end
                else if (is_special(held))
                begin
                    if (la_pair)
                    begin
                        dec.cls = CLS_PAIR;
                        nm      = MODE_PAIR2;
                    end
                    else
                    begin
                        dec.cls  = CLS_SINGLE;
                        dec.last = 1'b1;
                    end
                end
                else if (is_punct(held))
                begin
                    dec.cls  = CLS_PUNCT;
                    dec.last = !la_punct;
                    nm       = la_punct ? MODE_PUNCT : MODE_IDLE;
                end
                else
                begin
                    dec.cls  = CLS_INVALID;
                    dec.last = 1'b1;
                end
            end
        endcase
        dec.next_mode = eos ? MODE_IDLE : nm;
    end

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// testbench for the source token lexer: random and directed byte streams checked against a built-in lexer model
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import stl_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              eos;
        logic              pause;
    } word_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  tok;
        logic [CLASS_W-1:0] cls;
        logic               opens;
        logic               closes;
    } token_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [BYTE_W-1:0]   s_tdata = '0;
    logic                s_tuser = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [BYTE_W-1:0]   m_tdata;
    logic [CLASS_W:0]    m_tuser;
    logic                m_tlast;

    word_t  word_q[$];
    token_t token_q[$];

    logic [MODE_W-1:0] lx_mode = MODE_IDLE;
    logic [BYTE_W-1:0] lx_held = '0;
    logic              lx_held_ok = 1'b0;
    logic              lx_first = 1'b0;

    int          errors = 0;
    int          words_done = 0;
    int          tokens_checked = 0;
    logic [8:0]  class_seen = '0;
    int          rx_cycle = 0;
    int          hold_left = 0;

    logic [15:0] pair_ops [10] = '{
        {CH_LT, CH_LT}, {CH_GT, CH_GT}, {CH_COLON, CH_COLON}, {CH_PLUS, CH_PLUS},
        {CH_MINUS, CH_MINUS}, {CH_EQ, CH_EQ}, {CH_PLUS, CH_EQ}, {CH_MINUS, CH_EQ},
        {CH_STAR, CH_EQ}, {CH_SLASH, CH_EQ}
    };
    logic [7:0] single_ops [14] = '{
        CH_LT, CH_GT, CH_LBRK, CH_RBRK, CH_COLON, CH_LPAR, CH_RPAR,
        CH_LBRACE, CH_RBRACE, CH_EQ, CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH
    };
    logic [7:0] blanks [5] = '{8'd9, 8'd11, 8'd12, 8'd13, 8'd32};

    source_token_lexer_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // stream_byte
        .s_tuser  (s_tuser),    // end_of_stream
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // token_byte
        .m_tuser  (m_tuser),    // token_class, first_of_token
        .m_tlast  (m_tlast)     // last_of_token
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic ch_blank(input logic [7:0] c);
        return (c inside {8'd9, 8'd11, 8'd12, 8'd13, 8'd32});
    endfunction

    function automatic logic ch_alnum(input logic [7:0] c);
        return (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});
    endfunction

    function automatic logic ch_punct(input logic [7:0] c);
        return (c inside {[8'd33:8'd126]}) && !ch_alnum(c);
    endfunction

    function automatic logic ch_quote(input logic [7:0] c);
        return (c == CH_DQUOTE) || (c == CH_DOLLAR);
    endfunction

    function automatic logic ch_operator(input logic [7:0] c);
        return (c inside {CH_LT, CH_GT, CH_LBRK, CH_RBRK, CH_COLON, CH_LPAR, CH_RPAR,
                          CH_LBRACE, CH_RBRACE, CH_EQ, CH_PLUS, CH_MINUS, CH_STAR,
                          CH_SLASH});
    endfunction

    function automatic logic ch_pairs(input logic [7:0] h, input logic [7:0] n);
        logic ok;
        case (n)
            CH_EQ:   ok = (h inside {CH_EQ, CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH});
            default: ok = (n == h) && (h inside {CH_LT, CH_GT, CH_COLON, CH_PLUS, CH_MINUS});
        endcase
        return ok;
    endfunction

    // classify the held byte with n as lookahead (nok low means end of stream)
    task automatic decide_held(input logic [7:0] h, input logic [7:0] n, input logic nok);
        logic [CLASS_W-1:0] cls;
        logic               lst;
        logic               emit;
        logic               n_alnum;
        logic               n_punct;
        logic [MODE_W-1:0]  nxt;
        token_t             t;
        cls = CLS_ALNUM;
        lst = 1'b0;
        emit = 1'b1;
        nxt = MODE_IDLE;
        n_alnum = nok && ch_alnum(n);
        n_punct = nok && ch_punct(n);
        case (lx_mode)
            MODE_ALNUM:
            begin
                lst = !n_alnum;
                nxt = lst ? MODE_IDLE : MODE_ALNUM;
            end
            MODE_PUNCT:
            begin
                cls = CLS_PUNCT;
                lst = !n_punct;
                nxt = lst ? MODE_IDLE : MODE_PUNCT;
            end
            MODE_PAIR2:
            begin
                cls = CLS_PAIR;
                lst = 1'b1;
            end
            MODE_STRING:
            begin
                cls = CLS_STRING;
                lst = ch_quote(h) || !nok;
                nxt = lst ? MODE_IDLE : MODE_STRING;
            end
            MODE_LINE:
            begin
                cls = CLS_LINE;
                lst = !nok || (n == CH_NL);
                nxt = lst ? MODE_IDLE : MODE_LINE;
            end
            MODE_BOPEN:
            begin
                cls = CLS_BLOCK;
                lst = !nok;
                nxt = lst ? MODE_IDLE : MODE_BLOCK;
            end
            MODE_BLOCK:
            begin
                cls = CLS_BLOCK;
                if (h == CH_STAR && nok && n == CH_SLASH)
                begin
                    nxt = MODE_BEND;
                end
                else
                begin
                    lst = !nok;
                    nxt = lst ? MODE_IDLE : MODE_BLOCK;
                end
            end
            MODE_BEND:
            begin
                cls = CLS_BLOCK;
                lst = 1'b1;
            end
            default:
            begin
                if (ch_blank(h))
                begin
                    emit = 1'b0;
                end
                else if (h == CH_SLASH && nok && n == CH_SLASH)
                begin
                    cls = CLS_LINE;
                    nxt = MODE_LINE;
                end
                else if (h == CH_SLASH && nok && n == CH_STAR)
                begin
                    cls = CLS_BLOCK;
                    nxt = MODE_BOPEN;
                end
                else if (h == CH_NL)
                begin
                    cls = CLS_NEWLINE;
                    lst = 1'b1;
                end
                else if (ch_alnum(h))
                begin
                    lst = !n_alnum;
                    nxt = lst ? MODE_IDLE : MODE_ALNUM;
                end
                else if (ch_quote(h))
                begin
                    cls = CLS_STRING;
                    lst = !nok;
                    nxt = lst ? MODE_IDLE : MODE_STRING;
                end
                else if (ch_operator(h))
                begin
                    if (nok && ch_pairs(h, n))
                    begin
                        cls = CLS_PAIR;
                        nxt = MODE_PAIR2;
                    end
                    else
                    begin
                        cls = CLS_SINGLE;
                        lst = 1'b1;
                    end
                end
                else if (ch_punct(h))
                begin
                    cls = CLS_PUNCT;
                    lst = !n_punct;
                    nxt = lst ? MODE_IDLE : MODE_PUNCT;
                end
                else
                begin
                    cls = CLS_INVALID;
                    lst = 1'b1;
                end
            end
        endcase
        if (emit)
        begin
            t.tok = h;
            t.cls = cls;
            t.opens = lx_first;
            t.closes = lst;
            token_q.push_back(t);
            lx_mode = nok ? nxt : MODE_IDLE;
        end
        else
        begin
            lx_mode = MODE_IDLE;
        end
    endtask

    task automatic lex_word(input logic [7:0] c, input logic eos);
        if (eos)
        begin
            if (lx_held_ok)
                decide_held(lx_held, 8'd0, 1'b0);
            lx_held_ok = 1'b0;
            lx_held = '0;
            lx_first = 1'b0;
            lx_mode = MODE_IDLE;
        end
        else
        begin
            if (lx_held_ok)
                decide_held(lx_held, c, 1'b1);
            lx_held = c;
            lx_held_ok = 1'b1;
            lx_first = (lx_mode == MODE_IDLE);
        end
    endtask

    // every 500th word waits for the output side to drain
    task automatic push_word(input logic [7:0] c, input logic eos);
        word_t w;
        w.data = c;
        w.eos = eos;
        w.pause = (word_q.size() % 500 == 499);
        word_q.push_back(w);
    endtask

    function automatic logic [7:0] pick_alnum();
        int k;
        k = $urandom_range(0, 61);
        if (k < 10)
            return 8'(8'h30 + k);
        else if (k < 36)
            return 8'(8'h41 + k - 10);
        return 8'(8'h61 + k - 36);
    endfunction

    function automatic logic [7:0] pick_plain_punct();
        logic [7:0] c;
        c = 8'h41;
        while (ch_operator(c) || ch_quote(c) || !ch_punct(c))
            c = 8'($urandom_range(33, 126));
        return c;
    endfunction

    function automatic logic [7:0] pick_invalid();
        logic [7:0] c;
        c = 8'h41;
        while (ch_blank(c) || ch_punct(c) || ch_alnum(c) || c == CH_NL)
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic logic [7:0] pick_other_than(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] c;
        c = a;
        while (c == a || c == b)
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    task automatic push_token();
        int kind;
        int len;
        logic [7:0] q;
        logic [15:0] p;
        kind = $urandom_range(0, 99);
        len = $urandom_range(1, 6);
        if (kind < 18)
        begin
            repeat (len) push_word(pick_alnum(), 1'b0);
        end
        else if (kind < 26)
        begin
            repeat (len) push_word(pick_plain_punct(), 1'b0);
        end
        else if (kind < 38)
        begin
            push_word(single_ops[$urandom_range(0, 13)], 1'b0);
        end
        else if (kind < 50)
        begin
            p = pair_ops[$urandom_range(0, 9)];
            push_word(p[15:8], 1'b0);
            push_word(p[7:0], 1'b0);
        end
        else if (kind < 60)
        begin
            q = $urandom_range(0, 1) ? CH_DQUOTE : CH_DOLLAR;
            push_word(q, 1'b0);
            repeat (len) push_word(pick_other_than(CH_DQUOTE, CH_DOLLAR), 1'b0);
            push_word($urandom_range(0, 1) ? CH_DQUOTE : CH_DOLLAR, 1'b0);
        end
        else if (kind < 68)
        begin
            push_word(CH_SLASH, 1'b0);
            push_word(CH_SLASH, 1'b0);
            repeat (len) push_word(pick_other_than(CH_NL, CH_NL), 1'b0);
            push_word(CH_NL, 1'b0);
        end
        else if (kind < 76)
        begin
            push_word(CH_SLASH, 1'b0);
            push_word(CH_STAR, 1'b0);
            repeat (len) push_word(8'($urandom_range(0, 255)), 1'b0);
            push_word(CH_STAR, 1'b0);
            push_word(CH_SLASH, 1'b0);
        end
        else if (kind < 82)
        begin
            push_word(CH_NL, 1'b0);
        end
        else if (kind < 86)
        begin
            push_word(pick_invalid(), 1'b0);
        end
        else if (kind < 89)
        begin
            push_word(8'($urandom_range(0, 255)), 1'b1);
        end
        else
        begin
            repeat ($urandom_range(1, 3)) push_word(8'($urandom_range(0, 255)), 1'b0);
        end
        if ($urandom_range(0, 99) < 30)
            push_word(blanks[$urandom_range(0, 4)], 1'b0);
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin : drive
        logic  busy;
        logic  offer;
        word_t w;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= 1'b0;
        end
        else
        begin
            busy = s_tvalid;
            offer = 1'b0;
            if (s_tvalid && s_tready)
            begin
                lex_word(s_tdata, s_tuser);
                words_done = words_done + 1;
                busy = 1'b0;
            end
            if (!busy)
            begin
                if (word_q.size() > 0)
                begin
                    w = word_q[0];
                    if (w.pause && token_q.size() != 0)
                        offer = 1'b0;
                    else if ((words_done < 900 || words_done >= 1150)
                             && $urandom_range(0, 99) < 12)
                        offer = 1'b0;
                    else
                        offer = 1'b1;
                end
                if (offer)
                begin
                    w = word_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= w.data;
                    s_tuser <= w.eos;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_cycle <= 0;
            hold_left <= 0;
        end
        else
        begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle == 300)
            begin
                hold_left <= 80;
                m_tready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                m_tready <= 1'b0;
            end
            else if (rx_cycle >= 1200 && rx_cycle < 1700)
            begin
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= 12);
            end
        end
    end

    // output checker
    always @(posedge clk)
    begin : check
        token_t t;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (token_q.size() == 0)
            begin
                $display("%0t: unexpected word byte=%h class=%0d first=%b last=%b",
                         $time, m_tdata, m_tuser[CLASS_W-1:0], m_tuser[CLASS_W], m_tlast);
                errors = errors + 1;
            end
            else
            begin
                t = token_q.pop_front();
                tokens_checked = tokens_checked + 1;
                if (t.cls <= CLS_INVALID)
                    class_seen[t.cls] = 1'b1;
                if (m_tdata !== t.tok || m_tuser[CLASS_W-1:0] !== t.cls
                    || m_tuser[CLASS_W] !== t.opens || m_tlast !== t.closes)
                begin
                    $display("%0t: mismatch expected byte=%h class=%0d first=%b last=%b",
                             $time, t.tok, t.cls, t.opens, t.closes);
                    $display("%0t:          actual   byte=%h class=%0d first=%b last=%b",
                             $time, m_tdata, m_tuser[CLASS_W-1:0], m_tuser[CLASS_W],
                             m_tlast);
                    errors = errors + 1;
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : stimulus
        string s;
        s = "ab9 <<::+=\"q$/*/*/ //c\n";
        for (int i = 0; i < s.len(); i++)
            push_word(s[i], 1'b0);
        push_word(8'h00, 1'b0);
        push_word(8'hFF, 1'b0);
        push_word(8'h80, 1'b1);
        while (word_q.size() < 1620)
            push_token();
        push_word(8'($urandom_range(0, 255)), 1'b1);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (word_q.size() != 0 || s_tvalid || token_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("run covered %0d input words and %0d checked token bytes", words_done,
                 tokens_checked);
        $display("token classes seen (class 8 down to 0): %b", class_seen);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
